@@ rtl/m3h_pkg.sv @@
// ----------------------------------------------------------------------------
// m3h_pkg: shared types and constants of the 32-bit stream hash
// Holds the mix and finalizer multipliers and the controller/datapath links.
// ----------------------------------------------------------------------------
package m3h_pkg;

    localparam logic [31:0] MIX_C1 = 32'ha1f3e2d1;
    localparam logic [31:0] MIX_C2 = 32'h4df56a13;
    localparam logic [31:0] MIX_N  = 32'ha24f697f;
    localparam logic [31:0] FIN_M1 = 32'h85ebca6b;
    localparam logic [31:0] FIN_M2 = 32'hc2b2ae35;

    localparam int WORD_W  = 32;
    localparam int COUNT_W = 3;
    localparam int IN_TDATA_W = 40;

    localparam logic [COUNT_W-1:0] FULL_COUNT = 3'd4;

    // Operand selection of the shared multiplier.
    typedef enum logic [2:0] {
        MS_NONE = 3'd0,
        MS_C1   = 3'd1,
        MS_C2   = 3'd2,
        MS_M1   = 3'd3,
        MS_M2   = 3'd4
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        t_mul_sel mul_sel;
        logic     fold;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic out_busy;
    } t_sts;

endpackage

@@ rtl/m3h_ctrl.sv @@
// ----------------------------------------------------------------------------
// m3h_ctrl: sequencer of the 32-bit stream hash
// Steps each item through the mix and fold phases, and the last item through the finalizer.
// ----------------------------------------------------------------------------
module m3h_ctrl
    import m3h_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL1 = 7'b0000010,
        S_MUL2 = 7'b0000100,
        S_FOLD = 7'b0001000,
        S_FIN1 = 7'b0010000,
        S_FIN2 = 7'b0100000,
        S_FIN3 = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd.load     = 1'b0;
        o_cmd.mul_sel  = MS_NONE;
        o_cmd.fold     = 1'b0;
        o_cmd.out_load = 1'b0;
        o_in_ready     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.mul_sel = MS_C1;
                n_state       = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_sel = MS_C2;
                n_state       = S_FOLD;
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
                n_state    = i_sts.last ? S_FIN1 : S_IDLE;
            end
            S_FIN1: begin
                o_cmd.mul_sel = MS_M1;
                n_state       = S_FIN2;
            end
            S_FIN2: begin
                o_cmd.mul_sel = MS_M2;
                n_state       = S_FIN3;
            end
            S_FIN3: begin
                // Hold the finished hash until the output register is free.
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_fold_mid_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FOLD && !i_sts.last) |=> r_state == S_IDLE)
        else $error("non-final item did not return to idle after fold");

    a_fold_last_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FOLD && i_sts.last) |=> r_state == S_FIN1)
        else $error("final item did not enter finalization");

endmodule

@@ rtl/m3h_dp.sv @@
// ----------------------------------------------------------------------------
// m3h_dp: datapath of the 32-bit stream hash
// Input latch, one shared 32x32 multiplier, hash and length state, output reg.
// ----------------------------------------------------------------------------
module m3h_dp
    import m3h_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [WORD_W-1:0]  i_word,
    input  logic [COUNT_W-1:0] i_count,
    input  logic               i_last,
    input  logic               i_cfg_valid,
    input  logic [WORD_W-1:0]  i_cfg_data,
    output logic [WORD_W-1:0]  o_hash,
    output logic               o_hash_valid,
    input  logic               i_hash_ready
);

    logic [WORD_W-1:0]  r_seed;
    logic [WORD_W-1:0]  r_acc;
    logic [WORD_W-1:0]  r_total;
    logic               r_start;
    logic [WORD_W-1:0]  r_k;
    logic [COUNT_W-1:0] r_add;
    logic               r_full;
    logic               r_last;
    logic               r_zero;
    logic [WORD_W-1:0]  r_hash;
    logic               r_hash_valid;

    logic               full_in;
    logic [COUNT_W-1:0] cnt_sat;
    logic [WORD_W-1:0]  word_mask;
    logic [WORD_W-1:0]  mul_a;
    logic [WORD_W-1:0]  mul_b;
    logic [WORD_W-1:0]  mul_p;
    logic [WORD_W-1:0]  acc_x;
    logic [WORD_W-1:0]  acc_rot;
    logic [WORD_W-1:0]  acc_fold;
    logic [WORD_W-1:0]  fin_x;

    assign cnt_sat = (i_count > FULL_COUNT) ? FULL_COUNT : i_count;
    assign full_in = !i_last || (cnt_sat == FULL_COUNT);

    always_comb begin
        case (cnt_sat)
            3'd1:    word_mask = 32'h0000_00ff;
            3'd2:    word_mask = 32'h0000_ffff;
            3'd3:    word_mask = 32'h00ff_ffff;
            default: word_mask = 32'hffff_ffff;
        endcase
        if (full_in) begin
            word_mask = 32'hffff_ffff;
        end
    end

    assign fin_x = r_acc ^ r_total;

    always_comb begin
        unique case (i_cmd.mul_sel)
            MS_C1: begin
                mul_a = r_k;
                mul_b = MIX_C1;
            end
            MS_C2: begin
                mul_a = {r_k[16:0], r_k[31:17]};
                mul_b = MIX_C2;
            end
            MS_M1: begin
                mul_a = fin_x ^ (fin_x >> 16);
                mul_b = FIN_M1;
            end
            MS_M2: begin
                mul_a = r_k ^ (r_k >> 13);
                mul_b = FIN_M2;
            end
            default: begin
                mul_a = r_k;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Rotate by 13, then times five plus the additive constant.
    assign acc_x    = r_acc ^ r_k;
    assign acc_rot  = {acc_x[18:0], acc_x[31:19]};
    assign acc_fold = (acc_rot << 2) + acc_rot + MIX_N;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed       <= '0;
            r_acc        <= '0;
            r_total      <= '0;
            r_start      <= 1'b1;
            r_last       <= 1'b0;
            r_hash_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_seed <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_last <= i_last;
                if (r_start) begin
                    r_acc   <= r_seed;
                    r_total <= '0;
                    r_start <= 1'b0;
                end
            end
            if (i_cmd.fold) begin
                if (r_full) begin
                    r_acc <= acc_fold;
                end else if (!r_zero) begin
                    r_acc <= acc_x;
                end
                r_total <= r_total + WORD_W'(r_add);
                if (r_last) begin
                    r_start <= 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                r_hash_valid <= 1'b1;
            end else if (i_hash_ready) begin
                r_hash_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_k    <= i_word & word_mask;
            r_add  <= full_in ? FULL_COUNT : cnt_sat;
            r_full <= full_in;
            r_zero <= (cnt_sat == '0);
        end else if (i_cmd.mul_sel != MS_NONE) begin
            r_k <= mul_p;
        end
        if (i_cmd.out_load) begin
            r_hash <= r_k ^ (r_k >> 16);
        end
    end

    assign o_sts.last     = r_last;
    assign o_sts.out_busy = r_hash_valid && !i_hash_ready;
    assign o_hash         = r_hash;
    assign o_hash_valid   = r_hash_valid;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !(r_hash_valid && !i_hash_ready))
        else $error("pending hash overwritten");

    a_seed_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && r_start) |=> (r_acc == $past(r_seed) && r_total == '0))
        else $error("message start did not load the seed");

endmodule

@@ rtl/murmur3_style_hash32.sv @@
// ----------------------------------------------------------------------------
// murmur3_style_hash32: streaming 32-bit hash of little-endian word messages
// Channel table:
//   channel   dir  handshake                     contents
//   s_axis    in   s_axis_tvalid/s_axis_tready   data_word, byte_count, tlast
//   cfg       in   i_cfg_valid/o_cfg_ready       seed
//   m_axis    out  m_axis_tvalid/m_axis_tready   hash_value
// A word that is not last is handled in steps: accept, two passes through the one
// shared 32x32 multiplier, and the fold into the running hash.
// The last word also goes through the finalizer, which uses the same multiplier twice.
// Reset is synchronous, active low; the seed resets to zero.
// The finished hash sits in an output register, so new words are accepted
// while it waits. If it is still waiting when the next hash is done, the
// sequencer holds that hash and the input stalls until the output transfer.
// ----------------------------------------------------------------------------
module murmur3_style_hash32
    import m3h_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,  // data_word[31:0], byte_count[34:32], zero
    input  logic                  s_axis_tlast,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [WORD_W-1:0]     i_cfg_data,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [WORD_W-1:0]     m_axis_tdata   // hash_value[31:0]
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    m3h_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    m3h_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_word       (s_axis_tdata[WORD_W-1:0]),
        .i_count      (s_axis_tdata[WORD_W+COUNT_W-1:WORD_W]),
        .i_last       (s_axis_tlast),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .o_hash       (m_axis_tdata),
        .o_hash_valid (m_axis_tvalid),
        .i_hash_ready (m_axis_tready)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while previous word in progress");

endmodule
